/* hdl/swsr_pkg.sv */
// swsr_pkg: shared types and constants of the single-wire sensor reader
// no dependencies; used by the interfaces and every module under hdl

package swsr_pkg;

    localparam int BITS_PER_BYTE   = 8;
    localparam int MAX_FRAME_BYTES = 8;

    localparam int BIT_IDX_W  = $clog2(BITS_PER_BYTE);
    localparam int BYTE_IDX_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int FLEN_W     = $clog2(MAX_FRAME_BYTES + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SAMPLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd6;

    // response codes
    localparam logic [1:0] RESP_ABSENT  = 2'd0;
    localparam logic [1:0] RESP_PRESENT = 2'd1;
    localparam logic [1:0] RESP_BAD     = 2'd2;

    // input word function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef struct packed {
        logic [15:0] start_low_us;
        logic [7:0]  release_us;
        logic [7:0]  response_first_us;
        logic [7:0]  response_second_us;
        logic [7:0]  bit_sample_us;
        logic [3:0]  frame_bytes;
        logic [15:0] timeout_us;
    } t_cfg;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       response_valid;
        logic [1:0] response_code;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       byte_last;
        logic       timed_out;
    } t_res;

endpackage

/* hdl/swsr_intf.sv */
// swsr channel interfaces: tick/start input, result output, register writes
// depends on swsr_pkg

interface swsr_in_if;
    logic valid;
    logic ready;
    logic func;
    logic line_level;

    modport source (output valid, func, line_level, input ready);
    modport sink   (input valid, func, line_level, output ready);
endinterface

interface swsr_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       response_valid;
    logic [1:0] response_code;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       byte_last;
    logic       timed_out;

    modport source (output valid, drive_low, busy_res, response_valid, response_code,
                    byte_valid, data_byte, byte_last, timed_out, input ready);
    modport sink   (input valid, drive_low, busy_res, response_valid, response_code,
                    byte_valid, data_byte, byte_last, timed_out, output ready);
endinterface

interface swsr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [swsr_pkg::CFG_IDX_W-1:0]  index;
    logic [swsr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/swsr_cfg_regs.sv */
// swsr_cfg_regs: configuration register bank with reset defaults
// depends on swsr_pkg and swsr_cfg_if

module swsr_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    swsr_cfg_if.sink         i_cfg,
    output swsr_pkg::t_cfg   o_cfg
);

    swsr_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_us       <= 16'd18000;
            r_cfg.release_us         <= 8'd20;
            r_cfg.response_first_us  <= 8'd40;
            r_cfg.response_second_us <= 8'd80;
            r_cfg.bit_sample_us      <= 8'd40;
            r_cfg.frame_bytes        <= 4'd5;
            r_cfg.timeout_us         <= 16'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                swsr_pkg::REG_START_LOW:   r_cfg.start_low_us       <= i_cfg.data;
                swsr_pkg::REG_RELEASE:     r_cfg.release_us         <= i_cfg.data[7:0];
                swsr_pkg::REG_RESP_FIRST:  r_cfg.response_first_us  <= i_cfg.data[7:0];
                swsr_pkg::REG_RESP_SECOND: r_cfg.response_second_us <= i_cfg.data[7:0];
                swsr_pkg::REG_BIT_SAMPLE:  r_cfg.bit_sample_us      <= i_cfg.data[7:0];
                swsr_pkg::REG_FRAME_BYTES: r_cfg.frame_bytes        <= i_cfg.data[3:0];
                swsr_pkg::REG_TIMEOUT:     r_cfg.timeout_us         <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

/* hdl/swsr_step.sv */
// swsr_step: protocol state registers and the per-tick next-state logic
// depends on swsr_pkg

module swsr_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  swsr_pkg::t_cfg   i_cfg,
    input  logic             i_step,
    input  logic             i_func,
    input  logic             i_line,
    output swsr_pkg::t_res   o_res
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_LOW       = 4'd1;
    localparam logic [3:0] PH_RELEASE   = 4'd2;
    localparam logic [3:0] PH_RESP1     = 4'd3;
    localparam logic [3:0] PH_RESP2     = 4'd4;
    localparam logic [3:0] PH_RESP_FALL = 4'd5;
    localparam logic [3:0] PH_WAIT_HIGH = 4'd6;
    localparam logic [3:0] PH_BIT_DELAY = 4'd7;
    localparam logic [3:0] PH_WAIT_LOW  = 4'd8;

    localparam logic [swsr_pkg::BIT_IDX_W-1:0] LAST_BIT =
        swsr_pkg::BIT_IDX_W'(swsr_pkg::BITS_PER_BYTE - 1);

    logic [3:0]                          r_phase, n_phase;
    logic [15:0]                         r_us, n_us;
    logic [15:0]                         r_wait, n_wait;
    logic [swsr_pkg::BIT_IDX_W-1:0]      r_bit, n_bit;
    logic [swsr_pkg::BYTE_IDX_W-1:0]     r_byte, n_byte;
    logic [7:0]                          r_shift, n_shift;

    logic [15:0]                 tmr_len;
    logic                        tmr_done;
    logic [15:0]                 tmr_next;
    logic [15:0]                 wait_sat;
    logic                        wait_abort;
    logic [15:0]                 wait_next;
    logic [swsr_pkg::FLEN_W-1:0] frame_len;
    logic [7:0]                  shifted;
    logic                        last_byte;
    swsr_pkg::t_res              res;

    // length of the current timed phase
    always_comb begin
        case (r_phase)
            PH_LOW:       tmr_len = i_cfg.start_low_us;
            PH_RELEASE:   tmr_len = {8'd0, i_cfg.release_us};
            PH_RESP1:     tmr_len = {8'd0, i_cfg.response_first_us};
            PH_RESP2:     tmr_len = {8'd0, i_cfg.response_second_us};
            PH_BIT_DELAY: tmr_len = {8'd0, i_cfg.bit_sample_us};
            default:      tmr_len = 16'd0;
        endcase
    end

    assign tmr_done = (r_us >= tmr_len);
    assign tmr_next = tmr_done ? 16'd0 : r_us + 16'd1;

    // edge wait limit, counter saturates
    assign wait_sat   = (r_wait == 16'hFFFF) ? r_wait : r_wait + 16'd1;
    assign wait_abort = (i_cfg.timeout_us != 16'd0) && (wait_sat >= i_cfg.timeout_us);
    assign wait_next  = (i_cfg.timeout_us == 16'd0) ? r_wait : wait_sat;

    always_comb begin
        if (i_cfg.frame_bytes == 4'd0) begin
            frame_len = swsr_pkg::FLEN_W'(1);
        end else if (32'(i_cfg.frame_bytes) > swsr_pkg::MAX_FRAME_BYTES) begin
            frame_len = swsr_pkg::FLEN_W'(swsr_pkg::MAX_FRAME_BYTES);
        end else begin
            frame_len = swsr_pkg::FLEN_W'(i_cfg.frame_bytes);
        end
    end

    assign shifted   = {r_shift[6:0], i_line};
    assign last_byte = (swsr_pkg::FLEN_W'(r_byte) + swsr_pkg::FLEN_W'(1)) >= frame_len;

    always_comb begin
        n_phase = r_phase;
        n_us    = r_us;
        n_wait  = r_wait;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        res     = '0;

        if (i_func == swsr_pkg::FUNC_START) begin
            n_phase = PH_LOW;
            n_us    = 16'd0;
            n_wait  = 16'd0;
            n_bit   = '0;
            n_byte  = '0;
            n_shift = 8'd0;
        end else begin
            case (r_phase)
                PH_IDLE: ;
                PH_LOW: begin
                    n_us = tmr_next;
                    if (tmr_done) n_phase = PH_RELEASE;
                end
                PH_RELEASE: begin
                    n_us = tmr_next;
                    if (tmr_done) n_phase = PH_RESP1;
                end
                PH_RESP1: begin
                    n_us = tmr_next;
                    if (tmr_done) begin
                        if (!i_line) begin
                            n_phase = PH_RESP2;
                        end else begin
                            res.response_valid = 1'b1;
                            res.response_code  = swsr_pkg::RESP_ABSENT;
                            n_phase            = PH_IDLE;
                        end
                    end
                end
                PH_RESP2: begin
                    n_us = tmr_next;
                    if (tmr_done) begin
                        res.response_valid = 1'b1;
                        if (i_line) begin
                            res.response_code = swsr_pkg::RESP_PRESENT;
                            n_phase           = PH_RESP_FALL;
                            n_wait            = 16'd0;
                        end else begin
                            res.response_code = swsr_pkg::RESP_BAD;
                            n_phase           = PH_IDLE;
                        end
                    end
                end
                PH_RESP_FALL: begin
                    if (!i_line) begin
                        n_phase = PH_WAIT_HIGH;
                        n_wait  = 16'd0;
                        n_bit   = '0;
                        n_byte  = '0;
                        n_shift = 8'd0;
                    end else if (wait_abort) begin
                        n_phase       = PH_IDLE;
                        n_wait        = 16'd0;
                        res.timed_out = 1'b1;
                    end else begin
                        n_wait = wait_next;
                    end
                end
                PH_WAIT_HIGH: begin
                    if (i_line) begin
                        n_phase = PH_BIT_DELAY;
                        n_us    = 16'd0;
                        n_wait  = 16'd0;
                    end else if (wait_abort) begin
                        n_phase       = PH_IDLE;
                        n_wait        = 16'd0;
                        res.timed_out = 1'b1;
                    end else begin
                        n_wait = wait_next;
                    end
                end
                PH_BIT_DELAY: begin
                    n_us = tmr_next;
                    if (tmr_done) begin
                        n_phase = PH_WAIT_LOW;
                        n_wait  = 16'd0;
                        if (r_bit == LAST_BIT) begin
                            res.byte_valid = 1'b1;
                            res.data_byte  = shifted;
                            n_bit          = '0;
                            n_shift        = 8'd0;
                            if (last_byte) begin
                                res.byte_last = 1'b1;
                                n_byte        = '0;
                                n_phase       = PH_IDLE;
                                n_wait        = r_wait;
                            end else begin
                                n_byte = r_byte + swsr_pkg::BYTE_IDX_W'(1);
                            end
                        end else begin
                            n_bit   = r_bit + swsr_pkg::BIT_IDX_W'(1);
                            n_shift = shifted;
                        end
                    end
                end
                PH_WAIT_LOW: begin
                    if (!i_line) begin
                        n_phase = PH_WAIT_HIGH;
                        n_wait  = 16'd0;
                    end else if (wait_abort) begin
                        n_phase       = PH_IDLE;
                        n_wait        = 16'd0;
                        res.timed_out = 1'b1;
                    end else begin
                        n_wait = wait_next;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end

        res.drive_low = (n_phase == PH_LOW);
        res.busy_res  = (n_phase != PH_IDLE);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_us    <= 16'd0;
            r_wait  <= 16'd0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_us    <= n_us;
            r_wait  <= n_wait;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
        end
    end

endmodule

/* hdl/single_wire_sensor_reader.sv */
// single_wire_sensor_reader: top level, input word register, result register, handshakes
// depends on swsr_pkg, swsr_intf, swsr_cfg_regs and swsr_step

// host side of a single-wire temperature/humidity sensor link
// channels:
//   i_in  : one word per microsecond; func tick carries the sampled line level,
//           func start begins (or restarts) a transaction
//   o_res : exactly one result word per input word, in order: driver control
//           (drive_low), busy flag, response check result, received bytes,
//           timeout abort flag
//   i_cfg : register writes (index, data), always ready; write only while idle
// path: an accepted word waits in the input register and is stepped as it moves into
//   the result register, which holds its result on o_res
// throughput: one word per cycle while o_res.ready is high; the input register and the
//   result register form a two-stage pipe, so a new word is taken while a result waits
// stall: when o_res.ready is low the result register holds, the input register
//   fills, and i_in.ready drops only once both are occupied; nothing is lost
// reset: synchronous, active low; the state machine returns to idle, counters
//   clear, registers load their defaults (18000, 20, 40, 80, 40, 5 bytes,
//   timeout off) and both pipeline stages empty

module single_wire_sensor_reader (
    input  logic     i_clk,
    input  logic     i_rst_n,
    swsr_in_if.sink  i_in,
    swsr_cfg_if.sink i_cfg,
    swsr_res_if.source o_res
);

    swsr_pkg::t_cfg cfg;
    swsr_pkg::t_res step_res;

    // input word stage
    logic           r_in_valid, n_in_valid;
    logic           r_in_func;
    logic           r_in_line;

    // result stage
    logic           r_out_valid, n_out_valid;
    swsr_pkg::t_res r_out;

    logic           in_acc;
    logic           adv;

    // the stepped word moves into the result register when that is free or drains
    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready  = !r_in_valid || adv;
    assign in_acc      = i_in.valid && i_in.ready;
    assign n_in_valid  = in_acc || (r_in_valid && !adv);
    assign n_out_valid = adv || (r_out_valid && !o_res.ready);

    swsr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // state advances exactly once per word, when it enters the result register
    swsr_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (adv),
        .i_func  (r_in_func),
        .i_line  (r_in_line),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_func <= i_in.func;
            r_in_line <= i_in.line_level;
        end
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.drive_low      = r_out.drive_low;
    assign o_res.busy_res       = r_out.busy_res;
    assign o_res.response_valid = r_out.response_valid;
    assign o_res.response_code  = r_out.response_code;
    assign o_res.byte_valid     = r_out.byte_valid;
    assign o_res.data_byte      = r_out.data_byte;
    assign o_res.byte_last      = r_out.byte_last;
    assign o_res.timed_out      = r_out.timed_out;

    // last-byte flag only comes with a byte
    a_last_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.byte_last |-> r_out.byte_valid)
        else $error("byte_last without byte_valid");

    // the start pulse is part of a transaction
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.drive_low |-> r_out.busy_res)
        else $error("drive_low while not busy");

    // failed response or timeout ends the transaction
    a_fail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.timed_out ||
            (r_out.response_valid && r_out.response_code != swsr_pkg::RESP_PRESENT))
        |-> !r_out.busy_res)
        else $error("transaction still busy after failure");

    // a waiting input word is neither dropped nor altered while the result stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_func) && $stable(r_in_line))
        else $error("input word lost during stall");

endmodule
